>>> rtl/rob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_pkg
// Shared field widths, mode and result kind codes, and slot memory command
// type for the in-order completion reorder buffer.
// ----------------------------------------------------------------------------
package rob_pkg;

  localparam int MODE_W  = 2;
  localparam int TAG_W   = 16;
  localparam int PAY_W   = 32;
  localparam int KIND_W  = 3;
  localparam int TDATA_W = TAG_W + PAY_W;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [MODE_W-1:0] MODE_ISSUE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HELD    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OUTSIDE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FLUSHED = 3'd6;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_cmd_t;

endpackage
`default_nettype wire

>>> rtl/rob_slot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_slot_ram
// Slot payload store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rob_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire                    clk_i,
  input  wire  rob_pkg::ram_cmd_t cmd_i,
  input  wire  logic [AW-1:0]    waddr_i,
  input  wire  logic [WIDTH-1:0] wdata_i,
  input  wire  logic [AW-1:0]    raddr_i,
  output logic       [WIDTH-1:0] rdata_o
);
  import rob_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/rob_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_ctrl
// Tag window counters, slot valid bits, item sequencer and output register.
// ----------------------------------------------------------------------------
module rob_ctrl #(
  parameter int DEPTH        = 16,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 32,
  localparam int AW          = $clog2(DEPTH)
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_valid_i,
  output logic                                 s_ready_o,
  input  wire  logic [rob_pkg::MODE_W-1:0]     s_mode_i,
  input  wire  logic [rob_pkg::TAG_W-1:0]      s_tag_i,
  input  wire  logic [rob_pkg::PAY_W-1:0]      s_payload_i,
  output logic                                 m_valid_o,
  input  wire                                  m_ready_i,
  output logic       [rob_pkg::KIND_W-1:0]     m_kind_o,
  output logic       [rob_pkg::TAG_W-1:0]      m_tag_o,
  output logic       [rob_pkg::PAY_W-1:0]      m_payload_o,
  output logic                                 m_last_o,
  output rob_pkg::ram_cmd_t                    ram_cmd_o,
  output logic       [AW-1:0]                  ram_waddr_o,
  output logic       [PAYLOAD_BITS-1:0]        ram_wdata_o,
  output logic       [AW-1:0]                  ram_raddr_o,
  input  wire  logic [PAYLOAD_BITS-1:0]        ram_rdata_i
);
  import rob_pkg::*;

  localparam int SW = SEQ_BITS;
  localparam int PW = PAYLOAD_BITS;
  localparam logic [SW-1:0]   DEPTH_SEQ = SW'(DEPTH);
  localparam logic [SW-1:0]   SEQ_ONE   = SW'(1);
  localparam int              WRAP_MOD  = int'((64'd1 << SEQ_BITS) % DEPTH);
  localparam logic [AW+1:0]   WRAP_ADJ  = (AW+2)'(DEPTH - WRAP_MOD);
  localparam logic [AW+1:0]   DEPTH_X1  = (AW+2)'(DEPTH);
  localparam logic [AW+1:0]   DEPTH_X2  = (AW+2)'(2 * DEPTH);
  localparam logic [AW-1:0]   SLOT_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0]   SLOT_ONE  = AW'(1 % DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [SW-1:0]     tag_q, tag_d;
  logic [PW-1:0]     pay_q, pay_d;
  logic [SW-1:0]     head_q, head_d;
  logic [SW-1:0]     next_q, next_d;
  logic [AW-1:0]     head_slot_q, head_slot_d;
  logic [DEPTH-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] out_kind_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [PAY_W-1:0]  out_pay_q;
  logic              out_last_q;

  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic [TAG_W-1:0]  e_tag;
  logic [PAY_W-1:0]  e_pay;
  logic              e_last;

  logic [SW-1:0]     pending;
  logic [SW-1:0]     off;
  logic              out_free;
  logic [SW-1:0]     head_inc;
  logic [AW-1:0]     head_slot_inc;
  logic [AW+1:0]     slot_sum;
  logic [AW-1:0]     hold_slot;
  logic [CNT_W-1:0]  cnt_next;
  logic              more;

  assign pending  = next_q - head_q;
  assign off      = tag_q - head_q;
  assign out_free = !out_valid_q || m_ready_i;
  assign head_inc = head_q + SEQ_ONE;

  always_comb begin
    if (head_q == '1) begin
      head_slot_inc = '0;
    end else if (head_slot_q == SLOT_LAST) begin
      head_slot_inc = '0;
    end else begin
      head_slot_inc = head_slot_q + AW'(1);
    end
  end

  assign slot_sum = {2'b00, head_slot_q} + {2'b00, off[AW-1:0]}
                  + ((tag_q < head_q) ? WRAP_ADJ : '0);

  always_comb begin
    if (slot_sum >= DEPTH_X2) begin
      hold_slot = AW'(slot_sum - DEPTH_X2);
    end else if (slot_sum >= DEPTH_X1) begin
      hold_slot = AW'(slot_sum - DEPTH_X1);
    end else begin
      hold_slot = slot_sum[AW-1:0];
    end
  end

  assign cnt_next = (state_q == ST_DRAIN) ? cnt_q + CNT_ONE : CNT_ONE;
  assign more     = (cnt_next < CNT_MAX) && (head_inc != next_q) && valid_q[head_slot_inc];

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    tag_d       = tag_q;
    pay_d       = pay_q;
    head_d      = head_q;
    next_d      = next_q;
    head_slot_d = head_slot_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    emit        = 1'b0;
    e_kind      = KIND_GRANTED;
    e_tag       = '0;
    e_pay       = '0;
    e_last      = 1'b1;
    ram_cmd_o   = '0;
    ram_waddr_o = hold_slot;
    ram_wdata_o = pay_q;
    ram_raddr_o = head_slot_inc;

    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          mode_d  = s_mode_i;
          tag_d   = SW'(s_tag_i);
          pay_d   = PW'(s_payload_i);
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
          case (mode_q)
            MODE_ISSUE: begin
              emit = 1'b1;
              if (pending >= DEPTH_SEQ) begin
                e_kind = KIND_FULL;
              end else begin
                e_kind = KIND_GRANTED;
                e_tag  = TAG_W'(next_q);
                next_d = next_q + SEQ_ONE;
              end
            end
            MODE_COMPLETE: begin
              emit = 1'b1;
              if (off >= pending) begin
                e_kind = KIND_OUTSIDE;
                e_tag  = TAG_W'(tag_q);
              end else if (off != '0) begin
                ram_cmd_o.wr_en    = 1'b1;
                valid_d[hold_slot] = 1'b1;
                e_kind             = KIND_HELD;
                e_tag              = TAG_W'(tag_q);
              end else begin
                e_kind      = KIND_RELEASE;
                e_tag       = TAG_W'(head_q);
                e_pay       = PAY_W'(pay_q);
                e_last      = !more;
                head_d      = head_inc;
                head_slot_d = head_slot_inc;
                cnt_d       = cnt_next;
                if (more) begin
                  ram_cmd_o.rd_en = 1'b1;
                  state_d         = ST_DRAIN;
                end
              end
            end
            MODE_FLUSH: begin
              emit = 1'b1;
              if (pending != '0) begin
                e_kind = KIND_REFUSED;
              end else begin
                e_kind      = KIND_FLUSHED;
                valid_d     = '0;
                head_d      = SEQ_ONE;
                next_d      = SEQ_ONE;
                head_slot_d = SLOT_ONE;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit                 = 1'b1;
          e_kind               = KIND_RELEASE;
          e_tag                = TAG_W'(head_q);
          e_pay                = PAY_W'(ram_rdata_i);
          e_last               = !more;
          valid_d[head_slot_q] = 1'b0;
          head_d               = head_inc;
          head_slot_d          = head_slot_inc;
          cnt_d                = cnt_next;
          if (more) begin
            ram_cmd_o.rd_en = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= SEQ_ONE;
      next_q      <= SEQ_ONE;
      head_slot_q <= SLOT_ONE;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      next_q      <= next_d;
      head_slot_q <= head_slot_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    tag_q  <= tag_d;
    pay_q  <= pay_d;
    if (emit) begin
      out_kind_q <= e_kind;
      out_tag_q  <= e_tag;
      out_pay_q  <= e_pay;
      out_last_q <= e_last;
    end
  end

  assign s_ready_o   = (state_q == ST_IDLE);
  assign m_valid_o   = out_valid_q;
  assign m_kind_o    = out_kind_q;
  assign m_tag_o     = out_tag_q;
  assign m_payload_o = out_pay_q;
  assign m_last_o    = out_last_q;

endmodule
`default_nettype wire

>>> rtl/in_order_completion_reorder_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// in_order_completion_reorder_buffer
// Grants sequence tags, holds out-of-order completions in a slot memory and
// releases payloads strictly in tag order.
// ----------------------------------------------------------------------------
// One item is worked at a time. An issue, a held or rejected completion, a
// flush or an unused mode is accepted in the idle state; the execute state
// then updates the counters and valid bits and loads the output register,
// which an unused mode leaves alone. In a release of the head tag, each
// payload drained after the first is read from the single read port of the
// slot memory, one per cycle while the result port is not stalled, and a
// drain ends after 16 results. A stalled result port holds the sequencer, but
// the next item is accepted while a result still waits in the output register.
// ----------------------------------------------------------------------------
module in_order_completion_reorder_buffer #(
  parameter int DEPTH        = 16,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // tag [15:0], payload [47:16]
  input  wire  logic [rob_pkg::TDATA_W-1:0]   s_axis_tdata,
  // mode [1:0]
  input  wire  logic [rob_pkg::MODE_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // out_tag [15:0], out_payload [47:16]
  output logic       [rob_pkg::TDATA_W-1:0]   m_axis_tdata,
  // kind [2:0]
  output logic       [rob_pkg::KIND_W-1:0]    m_axis_tuser,
  output logic                                m_axis_tlast
);
  import rob_pkg::*;

  localparam int AW = $clog2(DEPTH);

  ram_cmd_t              ram_cmd;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_wdata;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic [TAG_W-1:0]      m_tag;
  logic [PAY_W-1:0]      m_payload;

  rob_ctrl #(
    .DEPTH        (DEPTH),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_mode_i    (s_axis_tuser),
    .s_tag_i     (s_axis_tdata[TAG_W-1:0]),
    .s_payload_i (s_axis_tdata[TDATA_W-1:TAG_W]),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_kind_o    (m_axis_tuser),
    .m_tag_o     (m_tag),
    .m_payload_o (m_payload),
    .m_last_o    (m_axis_tlast),
    .ram_cmd_o   (ram_cmd),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  rob_slot_ram #(
    .DEPTH (DEPTH),
    .WIDTH (PAYLOAD_BITS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .cmd_i   (ram_cmd),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = {m_payload, m_tag};

endmodule
`default_nettype wire

>>> rtl/rob_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_checker
// Port-level checks for the reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rob_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire logic [rob_pkg::TDATA_W-1:0]  m_axis_tdata,
  input wire logic [rob_pkg::KIND_W-1:0]   m_axis_tuser,
  input wire                               m_axis_tlast
);
  import rob_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous item in work");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_RELEASE) |-> m_axis_tlast)
    else $error("single result not marked last");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_RELEASE)
      |-> (m_axis_tdata[TDATA_W-1:TAG_W] == '0))
    else $error("payload nonzero on non-release result");

endmodule

bind in_order_completion_reorder_buffer rob_checker u_rob_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> sim/rob_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rob_scoreboard
// Watches both stream channels of the reorder buffer. On every accepted input
// item it predicts the result items, using its own copy of the tag counters
// and slot store. Each accepted result item is compared field by field with
// the oldest prediction. Mismatches and unexpected result items are counted
// for the testbench top.
// ----------------------------------------------------------------------------
module rob_scoreboard
  import rob_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  input  wire                      in_ready_i,
  input  wire  logic [TDATA_W-1:0] in_data_i,
  input  wire  logic [MODE_W-1:0]  in_mode_i,
  input  wire                      out_valid_i,
  input  wire                      out_ready_i,
  input  wire  logic [TDATA_W-1:0] out_data_i,
  input  wire  logic [KIND_W-1:0]  out_kind_i,
  input  wire                      out_last_i,
  output int                       fail_cnt_o,
  output int                       owed_cnt_o,
  output int                       checked_cnt_o,
  output logic [TAG_W-1:0]         head_tag_o,
  output logic [TAG_W-1:0]         next_tag_o
);

  localparam int SLOT_W = $clog2(DEPTH);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [PAY_W-1:0]  pay;
    logic              last;
  } rob_result_t;

  logic [PAY_W-1:0] slot_data  [DEPTH];
  logic             slot_valid [DEPTH];
  logic [TAG_W-1:0] head_tag;
  logic [TAG_W-1:0] next_tag;
  rob_result_t      owed_results [$];
  rob_result_t      oldest;
  int               fail_cnt    = 0;
  int               checked_cnt = 0;

  assign fail_cnt_o    = fail_cnt;
  assign checked_cnt_o = checked_cnt;
  assign head_tag_o    = head_tag;
  assign next_tag_o    = next_tag;

  function automatic logic [SLOT_W-1:0] slot_of(logic [TAG_W-1:0] tag);
    return SLOT_W'(tag % DEPTH);
  endfunction

  function automatic void owe(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                              logic [PAY_W-1:0] pay, logic last);
    rob_result_t r;
    r.kind = kind;
    r.tag  = tag;
    r.pay  = pay;
    r.last = last;
    owed_results.push_back(r);
  endfunction

  function automatic void predict_item(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                                       logic [PAY_W-1:0] pay);
    logic [TAG_W-1:0] in_flight;
    logic [TAG_W-1:0] offset;
    logic [TAG_W-1:0] cur;
    logic [PAY_W-1:0] data;
    int               drained;
    bit               more;
    in_flight = next_tag - head_tag;
    case (mode)
      MODE_ISSUE: begin
        if (in_flight >= DEPTH) begin
          owe(KIND_FULL, '0, '0, 1'b1);
        end else begin
          owe(KIND_GRANTED, next_tag, '0, 1'b1);
          next_tag = next_tag + TAG_W'(1);
        end
      end
      MODE_COMPLETE: begin
        offset = tag - head_tag;
        if (offset >= in_flight) begin
          owe(KIND_OUTSIDE, tag, '0, 1'b1);
        end else if (offset != '0) begin
          slot_data[slot_of(tag)]  = pay;
          slot_valid[slot_of(tag)] = 1'b1;
          owe(KIND_HELD, tag, '0, 1'b1);
        end else begin
          // release the head, then consecutive held payloads, up to MAX_RESULTS in all
          data    = pay;
          drained = 0;
          do begin
            cur      = head_tag;
            head_tag = head_tag + TAG_W'(1);
            drained++;
            more = drained < MAX_RESULTS && head_tag != next_tag &&
                   slot_valid[slot_of(head_tag)];
            owe(KIND_RELEASE, cur, data, !more);
            if (more) begin
              data = slot_data[slot_of(head_tag)];
              slot_valid[slot_of(head_tag)] = 1'b0;
            end
          end while (more);
        end
      end
      MODE_FLUSH: begin
        if (in_flight != '0) begin
          owe(KIND_REFUSED, '0, '0, 1'b1);
        end else begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
          head_tag = TAG_W'(1);
          next_tag = TAG_W'(1);
          owe(KIND_FLUSHED, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      head_tag = TAG_W'(1);
      next_tag = TAG_W'(1);
      owed_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual kind %0h tag %0h",
                   $time, out_kind_i, out_data_i[TAG_W-1:0]);
          fail_cnt++;
        end else begin
          oldest = owed_results.pop_front();
          check_field("kind", PAY_W'(oldest.kind), PAY_W'(out_kind_i));
          check_field("out_tag", PAY_W'(oldest.tag), PAY_W'(out_data_i[TAG_W-1:0]));
          check_field("out_payload", oldest.pay, out_data_i[TDATA_W-1:TAG_W]);
          check_field("last", PAY_W'(oldest.last), PAY_W'(out_last_i));
          checked_cnt++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_item(in_mode_i, in_data_i[TAG_W-1:0], in_data_i[TDATA_W-1:TAG_W]);
      end
    end
    owed_cnt_o = owed_results.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the in-order completion reorder buffer: directed corner cases,
// tag bursts completed in shuffled order, random noise, a long output stall
// and a burst with no idling on either side. A separate checker predicts and
// compares every result item; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import rob_pkg::*;

  localparam int               ROB_DEPTH      = 16;
  localparam int               LONG_HOLD      = 300;
  localparam int               WATCHDOG_LIMIT = 5000;
  localparam int               RANDOM_ITEMS   = 60;
  localparam int               TAIL_CYCLES    = 40;
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // tag [15:0], payload [47:16]
  logic [MODE_W-1:0]  s_axis_tuser;   // mode [1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // out_tag [15:0], out_payload [47:16]
  logic [KIND_W-1:0]  m_axis_tuser;   // kind [2:0]
  logic               m_axis_tlast;

  int               fail_cnt;
  int               owed_cnt;
  int               checked_cnt;
  logic [TAG_W-1:0] head_tag;
  logic [TAG_W-1:0] next_tag;
  int               items_sent   = 0;
  int               quiet_cycles = 0;
  bit               gaps_on      = 1'b1;
  bit               hold_tgl     = 1'b0;

  in_order_completion_reorder_buffer #(
    .DEPTH(ROB_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  rob_scoreboard #(
    .DEPTH(ROB_DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_mode_i     (s_axis_tuser),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .out_kind_i    (m_axis_tuser),
    .out_last_i    (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .owed_cnt_o    (owed_cnt),
    .checked_cnt_o (checked_cnt),
    .head_tag_o    (head_tag),
    .next_tag_o    (next_tag)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    bit hold_seen;
    hold_seen     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      m_axis_tready <= !(gaps_on && ($urandom_range(99) < 32));
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                       input logic [PAY_W-1:0] pay);
    while (gaps_on && ($urandom_range(99) < 32)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pay, tag};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode != MODE_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    wait (owed_cnt == 0);
    @(negedge clk_i);
  endtask

  // complete every outstanding tag, newest first, so the head drains them all
  task automatic retire_all();
    logic [TAG_W-1:0] base;
    logic [TAG_W-1:0] in_flight;
    base      = next_tag;
    in_flight = next_tag - head_tag;
    for (int i = 1; i <= int'(in_flight); i++) begin
      offer(MODE_COMPLETE, base - TAG_W'(i), $urandom);
    end
  endtask

  // issue n tags, then complete them in shuffled order (head tag last if head_last), some twice
  task automatic burst(int n, bit head_last);
    logic [TAG_W-1:0] base;
    int               order [ROB_DEPTH];
    int               span;
    int               j;
    int               tmp;
    base = next_tag;
    repeat (n) offer(MODE_ISSUE, TAG_W'($urandom), $urandom);
    for (int i = 0; i < n; i++) order[i] = head_last ? (i + 1) % n : i;
    span = head_last ? n - 1 : n;
    for (int i = span - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      offer(MODE_COMPLETE, base + TAG_W'(order[i]), $urandom);
      if ($urandom_range(9) == 0) offer(MODE_COMPLETE, base + TAG_W'(order[i]), $urandom);
    end
  endtask

  task automatic noise_item();
    logic [TAG_W-1:0] in_flight;
    int               r;
    in_flight = next_tag - head_tag;
    r         = $urandom_range(99);
    if (r < 30) begin
      offer(MODE_ISSUE, TAG_W'($urandom), $urandom);
    end else if (r < 55 && in_flight != '0) begin
      offer(MODE_COMPLETE, head_tag + TAG_W'($urandom_range(int'(in_flight) - 1)), $urandom);
    end else if (r < 65) begin
      offer(MODE_COMPLETE, next_tag, $urandom);
    end else if (r < 80) begin
      offer(MODE_COMPLETE, TAG_W'($urandom), $urandom);
    end else if (r < 92) begin
      offer(MODE_FLUSH, TAG_W'($urandom), $urandom);
    end else begin
      offer(MODE_UNUSED, TAG_W'($urandom), $urandom);
    end
  endtask

  initial begin
    int stop_at;
    int r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_ISSUE;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    offer(MODE_FLUSH, '0, '0);
    offer(MODE_COMPLETE, '0, '0);
    offer(MODE_COMPLETE, '1, '1);
    offer(MODE_UNUSED, '1, '1);
    repeat (ROB_DEPTH) offer(MODE_ISSUE, TAG_W'($urandom), $urandom);
    offer(MODE_ISSUE, '1, '1);
    offer(MODE_FLUSH, '0, '0);
    offer(MODE_COMPLETE, next_tag, '1);
    offer(MODE_COMPLETE, 16'd3, '1);
    offer(MODE_COMPLETE, 16'd3, '0);
    offer(MODE_COMPLETE, 16'd2, 32'h1234_5678);
    offer(MODE_COMPLETE, 16'd1, '0);
    retire_all();
    burst(ROB_DEPTH, 1'b1);

    // issue tags into the block while the result side holds off
    hold_tgl = ~hold_tgl;
    repeat (12) offer(MODE_ISSUE, TAG_W'($urandom), $urandom);
    retire_all();
    pause_until_drained();

    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 65) begin
        burst($urandom_range(1, ROB_DEPTH), $urandom_range(7) == 0);
      end else if (r < 70) begin
        retire_all();
      end else begin
        noise_item();
      end
    end

    // run a full burst with no idling on either side
    retire_all();
    pause_until_drained();
    gaps_on = 1'b0;
    offer(MODE_FLUSH, '0, '0);
    burst(ROB_DEPTH, 1'b0);
    gaps_on = 1'b1;
    retire_all();
    pause_until_drained();
    offer(MODE_FLUSH, '0, '0);
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d items sent, %0d result items checked", items_sent, checked_cnt);
    $display("covered full window, 16-payload drain, long output stall and idle-free burst");
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rob_pkg.sv
rtl/rob_slot_ram.sv
rtl/rob_ctrl.sv
rtl/in_order_completion_reorder_buffer.sv
rtl/rob_checker.sv
sim/rob_checker.sv
sim/tb.sv
